// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Needs signal clk in the scope of each use, and rst_n as well for HBSA_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define HBSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included
`define HBSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/hbsa_pkg.sv -----
// Shared types and constants for the header-tagged byte store allocator.
// No dependencies.
package hbsa_pkg;

    // Command codes carried in the input tuser
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [7:0] HDR_MARK  = 8'hA5;
    localparam logic [7:0] ERASED    = 8'hFF;
    localparam int         HDR_BYTES = 3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_FREE_CHK,
        ST_FWD_RD,
        ST_FWD_CHK,
        ST_BACK_RD,
        ST_BACK_CHK,
        ST_LEN0,
        ST_LEN1,
        ST_LEN2,
        ST_EVAL,
        ST_HDR,
        ST_STEP,
        ST_RD_CHK,
        ST_DONE
    } hbsa_state_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] read_data;
        logic       run_done;
    } hbsa_result_t;

endpackage

// ----- hdl/hbsa_store.sv -----
// Byte store: one write port, one read port with registered read data.
// No package dependencies.
module hbsa_store #(
    parameter int STORE_BYTES = 1024,
    localparam int AW = $clog2(STORE_BYTES)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/hbsa_ctrl.sv -----
// Sequencer: clear pass, run checks by store scans, header and payload access.
// Depends on hbsa_pkg and assert_macros.svh; drives the hbsa_store ports.
`include "assert_macros.svh"
module hbsa_ctrl #(
    parameter int STORE_BYTES = 1024,
    localparam int AW = $clog2(STORE_BYTES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_cmd,
    input  logic [10:0]           in_addr,
    input  logic [10:0]           in_count,
    input  logic [7:0]            in_data,
    input  logic                  in_last,
    output logic                  res_valid,
    input  logic                  res_take,
    output hbsa_pkg::hbsa_result_t res,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [7:0]            mem_wdata,
    output logic                  mem_re,
    output logic [AW-1:0]         mem_raddr,
    input  logic [7:0]            mem_rdata
);
    import hbsa_pkg::*;

    localparam int PW = ((AW > 11) ? AW : 11) + 2;
    localparam int EW = ((PW > 16) ? PW : 16) + 2;
    localparam logic [PW-1:0] SB_P     = PW'(STORE_BYTES);
    localparam logic [PW-1:0] HB_P     = PW'(HDR_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(STORE_BYTES - 1);

    hbsa_state_t  state_reg, state_next;
    logic [1:0]   cmd_reg, cmd_next;
    logic [10:0]  addr_reg, addr_next;
    logic [10:0]  cnt_reg, cnt_next;
    logic [7:0]   data_reg, data_next;
    logic         last_reg, last_next;
    logic         active_reg, active_next;
    logic         accepted_reg, accepted_next;
    logic [10:0]  offset_reg, offset_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0]  len_reg, len_next;
    logic [1:0]   hdr_reg, hdr_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic         rd_oor_reg, rd_oor_next;
    hbsa_result_t res_reg, res_next;

    logic [PW-1:0] a_p, n_p, end_p, off_p, rd_pos, wr_pos;
    logic [7:0]    peek;
    logic          is_mark, base_ok, xfer, wr_en;

    // Datapath helpers
    assign a_p     = PW'(addr_reg);
    assign n_p     = PW'(cnt_reg);
    assign end_p   = a_p + n_p;
    assign off_p   = PW'(offset_reg);
    assign peek    = rd_oor_reg ? ERASED : mem_rdata;
    assign is_mark = (peek == HDR_MARK);
    assign base_ok = (a_p >= HB_P) && (end_p <= SB_P);
    assign xfer    = accepted_reg && (offset_reg < cnt_reg);

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            active_reg   <= 1'b0;
            accepted_reg <= 1'b0;
            offset_reg   <= '0;
            clr_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            accepted_reg <= accepted_next;
            offset_reg   <= offset_next;
            clr_reg      <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        cnt_reg    <= cnt_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        len_reg    <= len_next;
        hdr_reg    <= hdr_next;
        rd_oor_reg <= rd_oor_next;
        res_reg    <= res_next;
    end

    // Next state and run bookkeeping
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        active_next   = active_reg;
        accepted_next = accepted_reg;
        offset_next   = offset_reg;
        ptr_next      = ptr_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        hdr_next      = hdr_reg;
        clr_next      = clr_reg;
        res_next      = res_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_cmd;
                    addr_next  = in_addr;
                    cnt_next   = in_count;
                    data_next  = in_data;
                    last_next  = in_last;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_FREE:
                    begin
                        if ((a_p >= HB_P) && (a_p <= SB_P))
                        begin
                            state_next = ST_FREE_CHK;
                        end
                        else
                        begin
                            res_next      = '{ok: 1'b0, read_data: 8'h00, run_done: 1'b1};
                            active_next   = 1'b0;
                            accepted_next = 1'b0;
                            offset_next   = '0;
                            state_next    = ST_DONE;
                        end
                    end
                    CMD_WRITE, CMD_READ:
                    begin
                        state_next = ST_STEP;
                        if (!active_reg)
                        begin
                            active_next = 1'b1;
                            offset_next = '0;
                            if (!base_ok)
                            begin
                                accepted_next = 1'b0;
                            end
                            else if (cmd_reg == CMD_WRITE)
                            begin
                                ptr_next   = a_p - HB_P;
                                state_next = ST_FWD_RD;
                            end
                            else
                            begin
                                ptr_next   = a_p;
                                state_next = ST_BACK_RD;
                            end
                        end
                    end
                    default:
                    begin
                        res_next   = '{ok: 1'b0, read_data: 8'h00, run_done: last_reg};
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_FREE_CHK:
            begin
                res_next      = '{ok: is_mark, read_data: 8'h00, run_done: 1'b1};
                active_next   = 1'b0;
                accepted_next = 1'b0;
                offset_next   = '0;
                state_next    = ST_DONE;
            end
            ST_FWD_RD:
            begin
                state_next = ST_FWD_CHK;
            end
            ST_FWD_CHK:
            begin
                if (is_mark)
                begin
                    accepted_next = 1'b0;
                    state_next    = ST_STEP;
                end
                else if (ptr_reg + 1'b1 == end_p)
                begin
                    if (a_p == HB_P)
                    begin
                        hdr_next   = '0;
                        state_next = ST_HDR;
                    end
                    else
                    begin
                        ptr_next   = a_p - HB_P - 1'b1;
                        state_next = ST_BACK_RD;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_FWD_RD;
                end
            end
            ST_BACK_RD:
            begin
                state_next = ST_BACK_CHK;
            end
            ST_BACK_CHK:
            begin
                if (is_mark)
                begin
                    pos_next   = ptr_reg;
                    state_next = ST_LEN0;
                end
                else if (ptr_reg == '0)
                begin
                    // no marker below: clear space for a write, miss for a read
                    if (cmd_reg == CMD_WRITE)
                    begin
                        hdr_next   = '0;
                        state_next = ST_HDR;
                    end
                    else
                    begin
                        accepted_next = 1'b0;
                        state_next    = ST_STEP;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = ST_BACK_RD;
                end
            end
            ST_LEN0:
            begin
                state_next = ST_LEN1;
            end
            ST_LEN1:
            begin
                len_next[15:8] = peek;
                state_next     = ST_LEN2;
            end
            ST_LEN2:
            begin
                len_next[7:0] = peek;
                state_next    = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (cmd_reg == CMD_WRITE)
                begin
                    // header slot must lie past the reach of the marker below
                    if (EW'(a_p - HB_P) - EW'(pos_reg) <= EW'(len_reg) + EW'(HB_P))
                    begin
                        accepted_next = 1'b0;
                        state_next    = ST_STEP;
                    end
                    else
                    begin
                        hdr_next   = '0;
                        state_next = ST_HDR;
                    end
                end
                else
                begin
                    accepted_next = (EW'(end_p) <= EW'(pos_reg) + EW'(len_reg) + EW'(HB_P));
                    state_next    = ST_STEP;
                end
            end
            ST_HDR:
            begin
                hdr_next = hdr_reg + 1'b1;
                if (hdr_reg == 2'd2)
                begin
                    accepted_next = 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (xfer && (cmd_reg == CMD_READ))
                begin
                    state_next = ST_RD_CHK;
                end
                else
                begin
                    res_next = '{ok: accepted_reg, read_data: 8'h00, run_done: last_reg};
                    if (xfer)
                    begin
                        offset_next = offset_reg + 1'b1;
                    end
                    if (last_reg)
                    begin
                        active_next = 1'b0;
                        offset_next = '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_RD_CHK:
            begin
                res_next    = '{ok: accepted_reg, read_data: peek, run_done: last_reg};
                offset_next = offset_reg + 1'b1;
                if (last_reg)
                begin
                    active_next = 1'b0;
                    offset_next = '0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store access per state
    always_comb
    begin
        mem_re    = 1'b0;
        rd_pos    = '0;
        wr_en     = 1'b0;
        wr_pos    = '0;
        mem_wdata = 8'h00;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_pos    = PW'(clr_reg);
                mem_wdata = ERASED;
            end
            ST_DISPATCH:
            begin
                mem_re = 1'b1;
                rd_pos = a_p - HB_P;
            end
            ST_FREE_CHK:
            begin
                wr_en  = is_mark;
                wr_pos = a_p - HB_P;
            end
            ST_FWD_RD, ST_BACK_RD:
            begin
                mem_re = 1'b1;
                rd_pos = ptr_reg;
            end
            ST_LEN0:
            begin
                mem_re = 1'b1;
                rd_pos = pos_reg + 1'b1;
            end
            ST_LEN1:
            begin
                mem_re = 1'b1;
                rd_pos = pos_reg + 2'd2;
            end
            ST_HDR:
            begin
                wr_en  = 1'b1;
                wr_pos = a_p - HB_P + PW'(hdr_reg);
                case (hdr_reg)
                    2'd0:    mem_wdata = HDR_MARK;
                    2'd1:    mem_wdata = {5'b00000, cnt_reg[10:8]};
                    default: mem_wdata = cnt_reg[7:0];
                endcase
            end
            ST_STEP:
            begin
                mem_re    = 1'b1;
                rd_pos    = a_p + off_p;
                wr_en     = xfer && (cmd_reg == CMD_WRITE);
                wr_pos    = a_p + off_p;
                mem_wdata = data_reg;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    assign mem_we      = wr_en && (wr_pos < SB_P);
    assign mem_waddr   = wr_pos[AW-1:0];
    assign mem_raddr   = rd_pos[AW-1:0];
    assign rd_oor_next = (rd_pos >= SB_P);

    // Handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        res       = res_reg;
    end

    `HBSA_ASSERT_ALWAYS(a_no_take_in_clear, (state_reg == ST_CLEAR) |-> !in_ready, "item taken during clear pass")
    `HBSA_ASSERT(a_res_held, (res_valid && !res_take) |=> (res_valid && $stable(res)), "result dropped before taken")
    `HBSA_ASSERT(a_hdr_in_range, (state_reg == ST_HDR) |-> (a_p >= HB_P && end_p <= SB_P), "header written outside checked span")

endmodule

// ----- hdl/header_tagged_byte_store_allocator_top.sv -----
// Top level of the header-tagged byte store allocator with its output register.
// Depends on hbsa_pkg, hbsa_store and hbsa_ctrl.
//
// Input stream s_axis: one item per write byte, read byte or free. tuser is the
// command, tlast marks the last item of a write or read run, tdata carries
// address, byte count and the payload byte. Output stream m_axis: one item per
// input item; tuser is the check verdict, tdata the byte read, tlast the run end
// (always set for a free).
// After reset the store is erased to 0xFF by a clear pass over all STORE_BYTES bytes,
// one byte a cycle; s_axis_tready stays low until that pass is over.
// Each item is dispatched and then handled in its own state; a payload read item
// adds a check of the byte read, a command-three item goes straight to its result.
// The first item of a run walks the store through the single read port: a write
// scans its span forward and then backward from its header to the nearest
// marker, a read scans back from its address; then a passing write writes its
// three header bytes.
// One item is in work at a time. A result moves into the output register, so
// the next item is taken while the receiver stalls; a second finished result
// waits until the output register is taken.
module header_tagged_byte_store_allocator_top #(
    parameter int STORE_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address[10:0], byte_count[21:11], data_byte[29:22]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // read_data[7:0]
    output logic        m_axis_tuser,   // ok[0]
    output logic        m_axis_tlast
);
    import hbsa_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic          res_valid, res_take;
    hbsa_result_t  res;
    logic          out_valid_reg, out_valid_next;
    hbsa_result_t  out_reg;

    hbsa_store #(.STORE_BYTES(STORE_BYTES)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hbsa_ctrl #(.STORE_BYTES(STORE_BYTES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .in_addr   (s_axis_tdata[10:0]),
        .in_count  (s_axis_tdata[21:11]),
        .in_data   (s_axis_tdata[29:22]),
        .in_last   (s_axis_tlast),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Output register
    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.read_data;
    assign m_axis_tuser  = out_reg.ok;
    assign m_axis_tlast  = out_reg.run_done;

endmodule
